FILE: rtl/core/clipped_circle_span_generator_assert.svh
// Assertion macros for the clipped circle span generator checks.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef CLIPPED_CIRCLE_SPAN_GENERATOR_ASSERT_SVH
`define CLIPPED_CIRCLE_SPAN_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCSG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clipped circle span generator check failed");

// The consequent must hold in the cycle after the antecedent.
`define CCSG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clipped circle span generator check failed");

`endif

FILE: rtl/core/ccsg_pkg.sv
// Shared types, codes and constants of the clipped circle span generator.
// Used by the interfaces and by every module of the block.
package ccsg_pkg;

    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_SURFACE_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SURFACE_HEIGHT = 2'd1;

    localparam logic [10:0] SurfaceReset = 11'd240;
    localparam logic [19:0] SqrtTopBit   = 20'h40000;

    typedef logic signed [10:0] coord_t;
    typedef logic signed [11:0] row_t;
    typedef logic [9:0]         size_t;
    typedef logic [4:0]         radius_t;
    typedef logic [10:0]        surf_t;

    typedef struct packed {
        logic        start;
        logic [19:0] operand;
    } sqrt_req_t;

    typedef struct packed {
        logic       done;
        logic [9:0] root;
    } sqrt_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PR2,
        ST_CR2,
        ST_ROW,
        ST_CSTART,
        ST_CWAIT,
        ST_OV2,
        ST_RSTART,
        ST_RWAIT,
        ST_CLIP,
        ST_EMIT
    } ctrl_state_t;

endpackage

FILE: rtl/core/ccsg_if.sv
// Channel interfaces of the clipped circle span generator: shape input,
// span output and configuration write. Depends on ccsg_pkg.
interface ccsg_in_if
    import ccsg_pkg::*;
();
    logic    valid;
    logic    ready;
    coord_t  rect_cx;
    coord_t  rect_cy;
    size_t   rect_half_w;
    size_t   rect_half_h;
    size_t   corner_r;
    coord_t  circle_x;
    coord_t  circle_y;
    radius_t circle_r;

    modport source (output valid, rect_cx, rect_cy, rect_half_w, rect_half_h, corner_r,
                    circle_x, circle_y, circle_r, input ready);
    modport sink (input valid, rect_cx, rect_cy, rect_half_w, rect_half_h, corner_r,
                  circle_x, circle_y, circle_r, output ready);
    modport mon (input valid, ready, rect_cx, rect_cy, rect_half_w, rect_half_h, corner_r,
                 circle_x, circle_y, circle_r);
endinterface

interface ccsg_out_if
    import ccsg_pkg::*;
();
    logic  valid;
    logic  ready;
    row_t  row_y;
    size_t span_x0;
    size_t span_x1;
    logic  visible;
    logic  last;

    modport source (output valid, row_y, span_x0, span_x1, visible, last, input ready);
    modport sink (input valid, row_y, span_x0, span_x1, visible, last, output ready);
    modport mon (input valid, ready, row_y, span_x0, span_x1, visible, last);
endinterface

interface ccsg_cfg_if
    import ccsg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    surf_t              data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
    modport mon (input valid, ready, index, data);
endinterface

FILE: rtl/core/ccsg_sqrt.sv
// Bit-by-bit integer square root of a 20-bit operand, one step per cycle.
// Depends on ccsg_pkg for the request and response structs.
module ccsg_sqrt
    import ccsg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic [19:0] rem_reg;
    logic [19:0] root_reg;
    logic [19:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [20:0] trial;
    logic        take;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign take  = {1'b0, rem_reg} >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.operand;
            root_reg <= '0;
            bit_reg  <= SqrtTopBit;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg  <= rem_reg - trial[19:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg[9:0];

endmodule

FILE: rtl/core/ccsg_ctrl.sv
// Row sequencer and datapath: walks the circle rows, drives the shared
// squarer and square root unit, and holds the output register. Uses ccsg_pkg.
module ccsg_ctrl
    import ccsg_pkg::*;
#(
    parameter int MAX_CIRCLE_R = 31
)
(
    input  logic          clk,
    input  logic          rst_n,
    ccsg_in_if.sink       shape_in,
    ccsg_out_if.source    span_out,
    input  surf_t         surf_w,
    input  surf_t         surf_h,
    output sqrt_req_t     sq_req,
    input  sqrt_rsp_t     sq_rsp
);

    localparam radius_t MaxR = radius_t'(MAX_CIRCLE_R);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    coord_t              rcx_reg;
    coord_t              rcy_reg;
    size_t               hw_reg;
    size_t               hh_reg;
    size_t               cr_reg;
    coord_t              px_reg;
    coord_t              py_reg;
    radius_t             pr_reg;
    logic [9:0]          pr2_reg;
    logic [19:0]         cr2_reg;
    logic signed [5:0]   dy_reg;
    logic [9:0]          dy2_reg;
    row_t                y_reg;
    logic [11:0]         ad_reg;
    logic                in_rect_reg;
    logic signed [12:0]  over_reg;
    logic [19:0]         over2_reg;
    logic [4:0]          dx_reg;
    size_t               hwrow_reg;
    logic signed [12:0]  x0n_reg;
    logic signed [12:0]  x1n_reg;
    logic                ok_reg;

    logic                out_valid_reg;
    row_t                row_y_reg;
    size_t               x0_reg;
    size_t               x1_reg;
    logic                vis_reg;
    logic                last_reg;

    logic                accept;
    logic                slot_free;
    logic                is_last;
    radius_t             pr_in;
    size_t               cr_in;
    size_t               cr_hw;
    logic [5:0]          abs_dy;
    logic [9:0]          sq_in;
    logic [19:0]         sq_prod;
    row_t                y_now;
    logic signed [12:0]  d_now;
    logic signed [12:0]  x0_raw;
    logic signed [12:0]  x1_raw;
    logic signed [12:0]  lo;
    logic signed [12:0]  hi;
    logic signed [12:0]  x0_rect;
    logic signed [12:0]  x1_rect;
    logic signed [12:0]  wm1;
    logic signed [12:0]  x0_fin;
    logic signed [12:0]  x1_fin;
    logic                vis_fin;

    assign accept    = shape_in.valid && shape_in.ready;
    assign slot_free = !out_valid_reg || span_out.ready;
    assign is_last   = dy_reg == $signed({1'b0, pr_reg});

    assign pr_in = (shape_in.circle_r > MaxR) ? MaxR : shape_in.circle_r;
    assign cr_hw = (shape_in.corner_r > shape_in.rect_half_w) ? shape_in.rect_half_w
                                                               : shape_in.corner_r;
    assign cr_in = (cr_hw > shape_in.rect_half_h) ? shape_in.rect_half_h : cr_hw;

    assign abs_dy  = dy_reg[5] ? 6'(-dy_reg) : 6'(dy_reg);
    assign sq_prod = 20'(sq_in) * 20'(sq_in);

    assign y_now = 12'(py_reg) + 12'(dy_reg);
    assign d_now = 13'(y_now) - 13'(rcy_reg);

    assign x0_raw  = 13'(px_reg) - $signed({8'b0, dx_reg});
    assign x1_raw  = 13'(px_reg) + $signed({8'b0, dx_reg});
    assign lo      = 13'(rcx_reg) - $signed({3'b0, hwrow_reg});
    assign hi      = 13'(rcx_reg) + $signed({3'b0, hwrow_reg});
    assign x0_rect = (x0_raw < lo) ? lo : x0_raw;
    assign x1_rect = (x1_raw > hi) ? hi : x1_raw;

    assign wm1     = $signed({2'b0, surf_w}) - 13'sd1;
    assign x0_fin  = x0n_reg[12] ? 13'sd0 : x0n_reg;
    assign x1_fin  = (x1n_reg > wm1) ? wm1 : x1n_reg;
    assign vis_fin = ok_reg && (x0_fin <= x1_fin);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PR2;
                end
            end
            ST_PR2:    state_next = ST_CR2;
            ST_CR2:    state_next = ST_ROW;
            ST_ROW:    state_next = ST_CSTART;
            ST_CSTART: state_next = ST_CWAIT;
            ST_CWAIT:
            begin
                if (sq_rsp.done)
                begin
                    if (!in_rect_reg || over_reg <= 13'sd0)
                    begin
                        state_next = ST_CLIP;
                    end
                    else
                    begin
                        state_next = ST_OV2;
                    end
                end
            end
            ST_OV2:    state_next = ST_RSTART;
            ST_RSTART: state_next = ST_RWAIT;
            ST_RWAIT:
            begin
                if (sq_rsp.done)
                begin
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = is_last ? ST_IDLE : ST_ROW;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        shape_in.ready = 1'b0;
        sq_in          = '0;
        sq_req.start   = 1'b0;
        sq_req.operand = '0;
        unique case (state_reg)
            ST_IDLE:   shape_in.ready = 1'b1;
            ST_PR2:    sq_in = {5'b0, pr_reg};
            ST_CR2:    sq_in = cr_reg;
            ST_ROW:    sq_in = {4'b0, abs_dy};
            ST_OV2:    sq_in = over_reg[9:0];
            ST_CSTART:
            begin
                sq_req.start   = 1'b1;
                sq_req.operand = {10'b0, pr2_reg - dy2_reg};
            end
            ST_RSTART:
            begin
                sq_req.start   = 1'b1;
                sq_req.operand = cr2_reg - over2_reg;
            end
            default:
            begin
                sq_in = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (span_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rcx_reg <= shape_in.rect_cx;
                    rcy_reg <= shape_in.rect_cy;
                    hw_reg  <= shape_in.rect_half_w;
                    hh_reg  <= shape_in.rect_half_h;
                    cr_reg  <= cr_in;
                    px_reg  <= shape_in.circle_x;
                    py_reg  <= shape_in.circle_y;
                    pr_reg  <= pr_in;
                    dy_reg  <= -$signed({1'b0, pr_in});
                end
            end
            ST_PR2: pr2_reg <= sq_prod[9:0];
            ST_CR2: cr2_reg <= sq_prod;
            ST_ROW:
            begin
                dy2_reg <= sq_prod[9:0];
                y_reg   <= y_now;
                ad_reg  <= d_now[12] ? 12'(-d_now) : 12'(d_now);
            end
            ST_CSTART:
            begin
                in_rect_reg <= (ad_reg <= {2'b0, hh_reg}) && (hw_reg != '0);
                over_reg    <= $signed({3'b0, cr_reg}) + $signed({1'b0, ad_reg})
                               - $signed({3'b0, hh_reg});
            end
            ST_CWAIT:
            begin
                dx_reg    <= sq_rsp.root[4:0];
                hwrow_reg <= hw_reg;
            end
            ST_OV2: over2_reg <= sq_prod;
            ST_RWAIT:
            begin
                if (sq_rsp.done)
                begin
                    hwrow_reg <= hw_reg - (cr_reg - sq_rsp.root);
                end
            end
            ST_CLIP:
            begin
                x0n_reg <= x0_rect;
                x1n_reg <= x1_rect;
                ok_reg  <= in_rect_reg && (x0_rect <= x1_rect) && !y_reg[11]
                           && (y_reg < $signed({1'b0, surf_h}));
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    row_y_reg <= y_reg;
                    x0_reg    <= vis_fin ? x0_fin[9:0] : 10'd0;
                    x1_reg    <= vis_fin ? x1_fin[9:0] : 10'd0;
                    vis_reg   <= vis_fin;
                    last_reg  <= is_last;
                    if (!is_last)
                    begin
                        dy_reg <= dy_reg + 6'sd1;
                    end
                end
            end
            default:
            begin
                dy_reg <= dy_reg;
            end
        endcase
    end

    assign span_out.valid   = out_valid_reg;
    assign span_out.row_y   = row_y_reg;
    assign span_out.span_x0 = x0_reg;
    assign span_out.span_x1 = x1_reg;
    assign span_out.visible = vis_reg;
    assign span_out.last    = last_reg;

endmodule

FILE: rtl/core/clipped_circle_span_generator.sv
// One shape beat (circle plus clipping rounded rectangle) yields 2*circle_r+1 row beats,
// one per row from the top of the circle down, the final one flagged last. Each row runs
// a 10-step square root for the chord and, where the row crosses a rectangle corner, a
// second one. An item runs setup steps before its rows, and an output stall holds a row;
// all square roots run in turn on the single shared square root unit. The input is not
// ready while an item is in work; the next item is taken while the final row beat still
// waits at the output. Surface size registers reset to 240; the user must write them only
// while the block is idle, since the block itself does not enforce it.
module clipped_circle_span_generator
    import ccsg_pkg::*;
#(
    parameter int MAX_CIRCLE_R = 31,
    parameter int MAX_SURFACE  = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    ccsg_in_if.sink    shape_in,
    ccsg_out_if.source span_out,
    ccsg_cfg_if.sink   cfg
);

    localparam logic [12:0] MaxSurf = 13'(MAX_SURFACE);

    surf_t     surface_width_reg;
    surf_t     surface_height_reg;
    surf_t     surf_w;
    surf_t     surf_h;
    sqrt_req_t sq_req;
    sqrt_rsp_t sq_rsp;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_width_reg  <= SurfaceReset;
            surface_height_reg <= SurfaceReset;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_SURFACE_WIDTH:  surface_width_reg  <= cfg.data;
                CFG_SURFACE_HEIGHT: surface_height_reg <= cfg.data;
                default:            surface_width_reg  <= surface_width_reg;
            endcase
        end
    end

    assign surf_w = ({2'b0, surface_width_reg} > MaxSurf) ? MaxSurf[10:0] : surface_width_reg;
    assign surf_h = ({2'b0, surface_height_reg} > MaxSurf) ? MaxSurf[10:0]
                                                            : surface_height_reg;

    ccsg_ctrl #(
        .MAX_CIRCLE_R(MAX_CIRCLE_R)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .shape_in (shape_in),
        .span_out (span_out),
        .surf_w   (surf_w),
        .surf_h   (surf_h),
        .sq_req   (sq_req),
        .sq_rsp   (sq_rsp)
    );

    ccsg_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

endmodule

FILE: rtl/core/ccsg_checker.sv
// Port-level checks of the clipped circle span generator and their binding.
// Depends on ccsg_pkg and the assertion macro header.
`include "clipped_circle_span_generator_assert.svh"

module ccsg_checker
    import ccsg_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input row_t  out_row_y,
    input size_t out_x0,
    input size_t out_x1,
    input logic  out_visible,
    input logic  out_last
);

    logic [33:0] out_beat;
    logic        out_stall;

    assign out_beat  = {out_row_y, out_x0, out_x1, out_visible, out_last};
    assign out_stall = out_valid && !out_ready;

    `CCSG_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_beat))
    `CCSG_ASSERT_SAME(a_hidden_zero, out_valid && !out_visible, out_x0 == '0 && out_x1 == '0)
    `CCSG_ASSERT_SAME(a_span_order, out_valid && out_visible, out_x0 <= out_x1)
    `CCSG_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

endmodule

bind clipped_circle_span_generator ccsg_checker u_ccsg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (shape_in.valid),
    .in_ready    (shape_in.ready),
    .out_valid   (span_out.valid),
    .out_ready   (span_out.ready),
    .out_row_y   (span_out.row_y),
    .out_x0      (span_out.span_x0),
    .out_x1      (span_out.span_x1),
    .out_visible (span_out.visible),
    .out_last    (span_out.last)
);

FILE: tb/sv/tb_clipped_circle_span_generator.sv
`timescale 1ns / 100ps
// Self-checking testbench for clipped_circle_span_generator: directed and randomized shapes,
// randomized span stalls and directed register writes, checked against an in-bench span
// predictor. Needs ccsg_pkg and the ccsg channel interfaces.
module tb_clipped_circle_span_generator;
    import ccsg_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          SETTLE_CYCLES  = 2000;
    localparam int          MAX_WAIT       = 12;
    localparam int          MAX_SURF       = 1024;
    localparam int unsigned SQRT_TOP       = 32'h4000_0000;

    typedef struct packed {
        coord_t  rect_cx;
        coord_t  rect_cy;
        size_t   rect_half_w;
        size_t   rect_half_h;
        size_t   corner_r;
        coord_t  circle_x;
        coord_t  circle_y;
        radius_t circle_r;
    } shape_t;

    typedef struct packed {
        row_t  row_y;
        size_t span_x0;
        size_t span_x1;
        logic  visible;
        logic  last;
    } span_beat_t;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        surf_t              data;
    } reg_write_t;

    logic clk;
    logic rst_n;

    ccsg_in_if  shape_if ();
    ccsg_out_if span_if ();
    ccsg_cfg_if cfg_if ();

    clipped_circle_span_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .shape_in (shape_if),
        .span_out (span_if),
        .cfg      (cfg_if)
    );

    shape_t     shape_queue[$];
    span_beat_t span_rows[$];
    reg_write_t reg_writes[$];
    shape_t     cur_shape;
    surf_t      surf_w;
    surf_t      surf_h;
    int         mismatches;
    int         idle_cycles;
    bit         src_idle_on;
    bit         sink_idle_on;
    int unsigned src_wait;
    int unsigned sink_wait;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned floor_sqrt(int unsigned n);
        int unsigned rem;
        int unsigned root;
        int unsigned step;
        rem  = n;
        root = 0;
        step = SQRT_TOP;
        while (step > rem)
            step >>= 2;
        while (step != 0) begin
            if (rem >= root + step) begin
                rem  -= root + step;
                root = (root >> 1) + step;
            end
            else begin
                root >>= 1;
            end
            step >>= 2;
        end
        return root;
    endfunction

    // Half width of the rounded rectangle at row offset d, or -1 when the row misses it.
    function automatic int rect_half_at(int hw, int hh, int cr, int d);
        int ad;
        int over;
        ad = (d < 0) ? -d : d;
        if (ad > hh || hw <= 0)
            return -1;
        if (cr > hw)
            cr = hw;
        if (cr > hh)
            cr = hh;
        over = cr - (hh - ad);
        if (over <= 0)
            return hw;
        return hw - (cr - int'(floor_sqrt(cr * cr - over * over)));
    endfunction

    function automatic void predict_spans(shape_t s);
        int rcx;
        int rcy;
        int px;
        int py;
        int pr;
        int w;
        int h;
        int dy;
        int y;
        int dx;
        int hw;
        int x0;
        int x1;
        bit vis;
        span_beat_t b;
        rcx = int'(s.rect_cx);
        rcy = int'(s.rect_cy);
        px  = int'(s.circle_x);
        py  = int'(s.circle_y);
        pr  = int'(s.circle_r);
        w   = (int'(surf_w) > MAX_SURF) ? MAX_SURF : int'(surf_w);
        h   = (int'(surf_h) > MAX_SURF) ? MAX_SURF : int'(surf_h);
        for (dy = -pr; dy <= pr; dy++) begin
            y   = py + dy;
            dx  = int'(floor_sqrt(pr * pr - dy * dy));
            hw  = rect_half_at(int'(s.rect_half_w), int'(s.rect_half_h), int'(s.corner_r),
                               y - rcy);
            vis = 1'b0;
            x0  = 0;
            x1  = 0;
            if (hw >= 0) begin
                x0 = px - dx;
                x1 = px + dx;
                if (x0 < rcx - hw)
                    x0 = rcx - hw;
                if (x1 > rcx + hw)
                    x1 = rcx + hw;
                if (x0 <= x1 && y >= 0 && y < h) begin
                    if (x0 < 0)
                        x0 = 0;
                    if (x1 > w - 1)
                        x1 = w - 1;
                    vis = (x0 <= x1);
                end
            end
            if (!vis) begin
                x0 = 0;
                x1 = 0;
            end
            b.row_y   = y[11:0];
            b.span_x0 = x0[9:0];
            b.span_x1 = x1[9:0];
            b.visible = vis;
            b.last    = (dy == pr);
            span_rows.push_back(b);
        end
    endfunction

    function automatic coord_t to_coord(int v);
        int c;
        c = (v < -1024) ? -1024 : ((v > 1023) ? 1023 : v);
        return c[10:0];
    endfunction

    function automatic shape_t make_shape(int rcx, int rcy, int hw, int hh, int cr,
                                          int cx, int cy, int r);
        shape_t s;
        s.rect_cx     = to_coord(rcx);
        s.rect_cy     = to_coord(rcy);
        s.rect_half_w = hw[9:0];
        s.rect_half_h = hh[9:0];
        s.corner_r    = cr[9:0];
        s.circle_x    = to_coord(cx);
        s.circle_y    = to_coord(cy);
        s.circle_r    = r[4:0];
        return s;
    endfunction

    // Most shapes land on the surface near their clipping rectangle; the rest are raw bits.
    function automatic shape_t random_shape(int w, int h);
        logic [95:0] raw;
        int ew;
        int eh;
        int cx;
        int cy;
        int r;
        int cr;
        raw = {$urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) < 3)
            return raw[78:0];
        ew = (w < 1) ? 1 : ((w > MAX_SURF) ? MAX_SURF : w);
        eh = (h < 1) ? 1 : ((h > MAX_SURF) ? MAX_SURF : h);
        cx = int'($urandom_range(0, ew + 80)) - 40;
        cy = int'($urandom_range(0, eh + 80)) - 40;
        r  = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 8))
                                         : int'($urandom_range(0, 31));
        cr = ($urandom_range(0, 7) == 0) ? 1023 : int'($urandom_range(0, 70));
        return make_shape(cx + int'($urandom_range(0, 80)) - 40,
                          cy + int'($urandom_range(0, 80)) - 40,
                          int'($urandom_range(0, 60)), int'($urandom_range(0, 60)), cr,
                          cx, cy, r);
    endfunction

    function automatic int unsigned draw_wait(bit enabled);
        if (!enabled || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void check_field(string name, logic signed [11:0] want,
                                        logic signed [11:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : cfg_driver
        if (!rst_n) begin
            cfg_if.valid <= 1'b0;
            cfg_if.index <= CFG_SURFACE_WIDTH;
            cfg_if.data  <= '0;
            surf_w       = SurfaceReset;
            surf_h       = SurfaceReset;
        end
        else begin
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == CFG_SURFACE_WIDTH)
                    surf_w = cfg_if.data;
                else if (cfg_if.index == CFG_SURFACE_HEIGHT)
                    surf_h = cfg_if.data;
            end
            if (!cfg_if.valid || cfg_if.ready) begin
                if (reg_writes.size() != 0) begin
                    cfg_if.index <= reg_writes[0].index;
                    cfg_if.data  <= reg_writes[0].data;
                    cfg_if.valid <= 1'b1;
                    void'(reg_writes.pop_front());
                end
                else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : shape_driver
        if (!rst_n) begin
            shape_if.valid       <= 1'b0;
            shape_if.rect_cx     <= '0;
            shape_if.rect_cy     <= '0;
            shape_if.rect_half_w <= '0;
            shape_if.rect_half_h <= '0;
            shape_if.corner_r    <= '0;
            shape_if.circle_x    <= '0;
            shape_if.circle_y    <= '0;
            shape_if.circle_r    <= '0;
            src_wait             <= 0;
        end
        else begin
            if (shape_if.valid && shape_if.ready)
                predict_spans(cur_shape);
            if (!shape_if.valid || shape_if.ready) begin
                if (src_wait != 0) begin
                    src_wait       <= src_wait - 1;
                    shape_if.valid <= 1'b0;
                end
                else if (shape_queue.size() != 0) begin
                    cur_shape = shape_queue.pop_front();
                    shape_if.rect_cx     <= cur_shape.rect_cx;
                    shape_if.rect_cy     <= cur_shape.rect_cy;
                    shape_if.rect_half_w <= cur_shape.rect_half_w;
                    shape_if.rect_half_h <= cur_shape.rect_half_h;
                    shape_if.corner_r    <= cur_shape.corner_r;
                    shape_if.circle_x    <= cur_shape.circle_x;
                    shape_if.circle_y    <= cur_shape.circle_y;
                    shape_if.circle_r    <= cur_shape.circle_r;
                    shape_if.valid       <= 1'b1;
                    src_wait             <= draw_wait(src_idle_on);
                end
                else begin
                    shape_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : span_monitor
        int unsigned wait_n;
        span_beat_t  want;
        if (!rst_n) begin
            span_if.ready <= 1'b0;
            sink_wait     <= 0;
        end
        else if (span_if.valid && span_if.ready) begin
            if (span_rows.size() == 0) begin
                $error("unexpected span beat: row_y %0d", span_if.row_y);
                mismatches++;
            end
            else begin
                want = span_rows.pop_front();
                check_field("row_y", want.row_y, span_if.row_y);
                check_field("span_x0", want.span_x0, span_if.span_x0);
                check_field("span_x1", want.span_x1, span_if.span_x1);
                check_field("visible", want.visible, span_if.visible);
                check_field("last", want.last, span_if.last);
            end
            wait_n = draw_wait(sink_idle_on);
            span_if.ready <= (wait_n == 0);
            sink_wait     <= (wait_n == 0) ? 0 : wait_n - 1;
        end
        else if (sink_wait != 0) begin
            sink_wait     <= sink_wait - 1;
            span_if.ready <= 1'b0;
        end
        else begin
            span_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (shape_if.valid && shape_if.ready) || (span_if.valid && span_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic drain_spans();
        while (shape_queue.size() != 0 || shape_if.valid || span_rows.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_surface(int w, int h);
        reg_write_t wr;
        drain_spans();
        wr.index = CFG_SURFACE_WIDTH;
        wr.data  = w[10:0];
        reg_writes.push_back(wr);
        wr.index = CFG_SURFACE_HEIGHT;
        wr.data  = h[10:0];
        reg_writes.push_back(wr);
        while (reg_writes.size() != 0 || cfg_if.valid)
            @(posedge clk);
    endtask

    task automatic run_random(int count, bit src_idle, bit sink_idle);
        src_idle_on  = src_idle;
        sink_idle_on = sink_idle;
        repeat (count)
            shape_queue.push_back(random_shape(int'(surf_w), int'(surf_h)));
        drain_spans();
    endtask

    initial begin
        rst_n        = 1'b0;
        mismatches   = 0;
        idle_cycles  = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed shapes on the reset surface size.
        shape_queue.push_back(make_shape(0, 0, 0, 0, 0, 0, 0, 0));
        shape_queue.push_back(make_shape(120, 120, 200, 200, 0, 120, 120, 10));
        shape_queue.push_back(make_shape(120, 120, 20, 20, 10, 120, 120, 31));
        shape_queue.push_back(make_shape(100, 100, 30, 15, 1023, 100, 100, 25));
        shape_queue.push_back(make_shape(60, 60, 80, 3, 0, 60, 60, 12));
        shape_queue.push_back(make_shape(50, 0, 0, 400, 5, 50, 50, 8));
        shape_queue.push_back(make_shape(100, 5, 200, 200, 0, 100, 5, 20));
        shape_queue.push_back(make_shape(100, 235, 200, 200, 0, 100, 235, 20));
        shape_queue.push_back(make_shape(0, 100, 300, 300, 0, -10, 100, 20));
        shape_queue.push_back(make_shape(200, 100, 300, 300, 0, 235, 100, 20));
        shape_queue.push_back(make_shape(200, 100, 5, 50, 0, 50, 100, 15));
        shape_queue.push_back(make_shape(-100, 100, 40, 40, 0, -100, 100, 10));
        shape_queue.push_back(make_shape(-1024, 1023, 1023, 1023, 1023, -1024, -1024, 31));
        shape_queue.push_back(make_shape(1023, -1024, 1023, 1023, 1023, 1023, 1023, 31));
        shape_queue.push_back(make_shape(1023, 1023, 1023, 1023, 0, 0, 0, 31));
        shape_queue.push_back(make_shape(10, 10, 1, 0, 0, 10, 10, 1));
        shape_queue.push_back(make_shape(30, 30, 6, 6, 6, 30, 30, 9));
        drain_spans();
        run_random(40, 1'b1, 1'b1);

        set_surface(1024, 1024);
        run_random(70, 1'b1, 1'b1);
        set_surface(2047, 2047);
        run_random(40, 1'b0, 1'b0);
        set_surface(1, 1);
        run_random(30, 1'b1, 1'b0);
        set_surface(0, 300);
        run_random(30, 1'b0, 1'b1);
        set_surface(500, 0);
        run_random(25, 1'b1, 1'b1);
        set_surface(640, 480);
        run_random(80, 1'b1, 1'b1);
        set_surface(1025, 17);
        run_random(40, 1'b1, 1'b1);
        set_surface(240, 240);
        run_random(70, 1'b1, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && span_rows.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
